[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the timer top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/stc_pkg.sv]
// ---------------------------------------------------------------------------
// stc_pkg
// Types and constants of the seconds countdown timer.
// ---------------------------------------------------------------------------
package stc_pkg;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // Divide-by-3600 as multiply by ceil(2^27 / 3600), exact for 16-bit values
    localparam logic [15:0] HOUR_RECIP    = 16'd37283;
    localparam int          HOUR_SHIFT    = 27;
    localparam logic [15:0] SEC_PER_HOUR  = 16'd3600;
    // Divide-by-60 as multiply by ceil(2^18 / 60), exact below 3600
    localparam logic [12:0] MIN_RECIP     = 13'd4370;
    localparam int          MIN_SHIFT     = 18;
    localparam logic [11:0] SEC_PER_MIN   = 12'd60;

    // State update result, first pipeline stage
    typedef struct packed {
        logic [15:0] remaining;
        logic        expired;
        logic        by_win;
        logic        running;
    } t_s1;

    // After the hour split, second pipeline stage
    typedef struct packed {
        logic [4:0]  hours;
        logic [11:0] in_hour;
        logic [15:0] remaining;
        logic        urgent;
        logic        expired;
        logic        by_win;
        logic        running;
    } t_s2;

    // Final result item
    typedef struct packed {
        logic [15:0] remaining;
        logic        urgent;
        logic        expired;
        logic        by_win;
        logic        running;
        logic        hours_tens;
        logic [3:0]  hours_ones;
        logic [2:0]  minutes_tens;
        logic [3:0]  minutes_ones;
        logic [2:0]  seconds_tens;
        logic [3:0]  seconds_ones;
    } t_result;

endpackage

[hw/rtl/stc_core.sv]
// ---------------------------------------------------------------------------
// stc_core
// Countdown state, prescaler and configuration register; registers the
// updated state of each accepted transaction into the first stage.
// ---------------------------------------------------------------------------
module stc_core #(
    parameter int FRAMES_PER_SECOND = 60
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_accept,
    input  logic [1:0]       i_command,
    input  logic             i_freeze,
    input  logic             i_win,
    output logic [15:0]      o_cfg,
    output stc_pkg::t_s1     o_s1
);
    import stc_pkg::*;

    localparam logic [5:0] FPS = 6'(FRAMES_PER_SECOND);

    logic [15:0] r_cfg;
    logic [15:0] r_rem, n_rem;
    logic [5:0]  r_frame, n_frame;
    logic        r_active, n_active;
    logic        n_expired, n_by_win;
    logic [5:0]  frame_inc;
    logic [15:0] rem_dec;
    t_s1         r_s1;

    assign frame_inc = r_frame + 6'd1;
    assign rem_dec   = r_rem - 16'd1;

    always_comb begin
        n_rem     = r_rem;
        n_frame   = r_frame;
        n_active  = r_active;
        n_expired = 1'b0;
        n_by_win  = 1'b0;
        unique case (t_cmd'(i_command))
            CMD_RESET: begin
                n_rem    = r_cfg;
                n_active = 1'b0;
                n_frame  = 6'd0;
            end
            CMD_START: begin
                if (!r_active) begin
                    if (r_cfg == 16'd0) begin
                        n_rem = 16'd0;
                    end else begin
                        if (r_rem == 16'd0 || r_rem > r_cfg) begin
                            n_rem = r_cfg;
                        end
                        n_active = 1'b1;
                        n_frame  = 6'd0;
                    end
                end
            end
            CMD_TICK: begin
                if (r_active && r_rem != 16'd0 && !i_freeze) begin
                    if (frame_inc >= FPS) begin
                        n_frame = 6'd0;
                        if (i_win) begin
                            // win wins over reaching zero on the same boundary
                            n_rem    = 16'd0;
                            n_active = 1'b0;
                            n_by_win = 1'b1;
                        end else begin
                            n_rem = rem_dec;
                            if (rem_dec == 16'd0) begin
                                n_active  = 1'b0;
                                n_expired = 1'b1;
                            end
                        end
                    end else begin
                        n_frame = frame_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= 16'd0;
            r_rem    <= 16'd0;
            r_frame  <= 6'd0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_accept) begin
                r_rem    <= n_rem;
                r_frame  <= n_frame;
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1.remaining <= n_rem;
            r_s1.expired   <= n_expired;
            r_s1.by_win    <= n_by_win;
            r_s1.running   <= n_active;
        end
    end

    assign o_cfg = r_cfg;
    assign o_s1  = r_s1;

endmodule

[hw/rtl/stc_hour_split.sv]
// ---------------------------------------------------------------------------
// stc_hour_split
// Splits the remainder into whole hours and seconds within the hour and
// evaluates the urgency flag.
// ---------------------------------------------------------------------------
module stc_hour_split (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [15:0]      i_cfg,
    input  stc_pkg::t_s1     i_s1,
    output stc_pkg::t_s2     o_s2
);
    import stc_pkg::*;

    logic [31:0] hour_prod;
    logic [4:0]  hours;
    logic [15:0] hour_secs;
    logic [15:0] in_hour;
    logic        urgent;
    t_s2         r_s2;

    assign hour_prod = 32'(i_s1.remaining) * 32'(HOUR_RECIP);
    assign hours     = hour_prod[HOUR_SHIFT +: 5];
    assign hour_secs = 16'(hours) * SEC_PER_HOUR;
    assign in_hour   = i_s1.remaining - hour_secs;
    assign urgent    = (i_cfg != 16'd0) && (i_s1.remaining <= {1'b0, i_cfg[15:1]});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2.hours     <= hours;
            r_s2.in_hour   <= in_hour[11:0];
            r_s2.remaining <= i_s1.remaining;
            r_s2.urgent    <= urgent;
            r_s2.expired   <= i_s1.expired;
            r_s2.by_win    <= i_s1.by_win;
            r_s2.running   <= i_s1.running;
        end
    end

    assign o_s2 = r_s2;

endmodule

[hw/rtl/stc_digit_split.sv]
// ---------------------------------------------------------------------------
// stc_digit_split
// Minutes and seconds split and decimal digits; holds the result register.
// ---------------------------------------------------------------------------
module stc_digit_split (
    input  logic               i_clk,
    input  logic               i_load,
    input  stc_pkg::t_s2       i_s2,
    output stc_pkg::t_result   o_result
);
    import stc_pkg::*;

    // Tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60) begin
            t = 3'd6;
        end else if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    logic [24:0] min_prod;
    logic [5:0]  minutes;
    logic [11:0] min_secs;
    logic [11:0] secs_full;
    logic [5:0]  seconds;
    logic [2:0]  m_tens, s_tens;
    logic [5:0]  m_ones, s_ones;
    logic        h_tens;
    logic [4:0]  h_ones;
    t_result     r_out;

    assign min_prod  = 25'(i_s2.in_hour) * 25'(MIN_RECIP);
    assign minutes   = min_prod[MIN_SHIFT +: 6];
    assign min_secs  = 12'(minutes) * SEC_PER_MIN;
    assign secs_full = i_s2.in_hour - min_secs;
    assign seconds   = secs_full[5:0];

    assign m_tens = tens_of(minutes);
    assign s_tens = tens_of(seconds);
    assign m_ones = minutes - 6'(m_tens) * 6'd10;
    assign s_ones = seconds - 6'(s_tens) * 6'd10;
    assign h_tens = (i_s2.hours >= 5'd10);
    assign h_ones = h_tens ? (i_s2.hours - 5'd10) : i_s2.hours;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.remaining    <= i_s2.remaining;
            r_out.urgent       <= i_s2.urgent;
            r_out.expired      <= i_s2.expired;
            r_out.by_win       <= i_s2.by_win;
            r_out.running      <= i_s2.running;
            r_out.hours_tens   <= h_tens;
            r_out.hours_ones   <= h_ones[3:0];
            r_out.minutes_tens <= m_tens;
            r_out.minutes_ones <= m_ones[3:0];
            r_out.seconds_tens <= s_tens;
            r_out.seconds_ones <= s_ones[3:0];
        end
    end

    assign o_result = r_out;

endmodule

[hw/rtl/seconds_countdown_timer.sv]
// Three register stages (state update, hour split, digit split) carry an
// accepted transaction to the output; each loads when the next is empty or
// moving on. Throughput: one transaction per cycle while i_ready is high.
// Reset (i_rst_n low, synchronous): count and prescaler cleared, timer
// stopped, configured length 0, pipeline emptied.
// ---------------------------------------------------------------------------
// seconds_countdown_timer
// Seconds countdown with a frame prescaler and h:m:s digit outputs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module seconds_countdown_timer #(
    parameter int FRAMES_PER_SECOND = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_configured_seconds,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic        i_freeze,
    input  logic        i_win,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_remaining_seconds,
    output logic        o_urgent,
    output logic        o_expired,
    output logic        o_stopped_by_win,
    output logic        o_running,
    output logic        o_hours_tens,
    output logic [3:0]  o_hours_ones,
    output logic [2:0]  o_minutes_tens,
    output logic [3:0]  o_minutes_ones,
    output logic [2:0]  o_seconds_tens,
    output logic [3:0]  o_seconds_ones
);
    import stc_pkg::*;

    logic        r_v1, r_v2, r_vo;
    logic        accept, load2, load_o;
    logic [15:0] cfg;
    t_s1         s1;
    t_s2         s2;
    t_result     res;

    assign load_o  = r_v2 && (!r_vo || i_ready);
    assign load2   = r_v1 && (!r_v2 || load_o);
    assign o_ready = !r_v1 || load2;
    assign accept  = i_valid && o_ready;

    // urgency is evaluated a stage after the state update, so the length
    // only changes with the pipeline empty and no command transaction offered
    assign o_cfg_ready = !r_v1 && !r_v2 && !r_vo && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (load2) begin
                r_v1 <= 1'b0;
            end
            if (load2) begin
                r_v2 <= 1'b1;
            end else if (load_o) begin
                r_v2 <= 1'b0;
            end
            if (load_o) begin
                r_vo <= 1'b1;
            end else if (i_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    stc_core #(
        .FRAMES_PER_SECOND (FRAMES_PER_SECOND)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_configured_seconds),
        .i_accept   (accept),
        .i_command  (i_command),
        .i_freeze   (i_freeze),
        .i_win      (i_win),
        .o_cfg      (cfg),
        .o_s1       (s1)
    );

    stc_hour_split u_hour (
        .i_clk  (i_clk),
        .i_load (load2),
        .i_cfg  (cfg),
        .i_s1   (s1),
        .o_s2   (s2)
    );

    stc_digit_split u_digit (
        .i_clk    (i_clk),
        .i_load   (load_o),
        .i_s2     (s2),
        .o_result (res)
    );

    assign o_valid             = r_vo;
    assign o_remaining_seconds = res.remaining;
    assign o_urgent            = res.urgent;
    assign o_expired           = res.expired;
    assign o_stopped_by_win    = res.by_win;
    assign o_running           = res.running;
    assign o_hours_tens        = res.hours_tens;
    assign o_hours_ones        = res.hours_ones;
    assign o_minutes_tens      = res.minutes_tens;
    assign o_minutes_ones      = res.minutes_ones;
    assign o_seconds_tens      = res.seconds_tens;
    assign o_seconds_ones      = res.seconds_ones;

    // digits from the reciprocal split stay decimal and in range
    `ASSERT_IMPL(a_digits_range, i_clk, i_rst_n, r_vo,
        res.hours_ones <= 4'd9 && res.minutes_tens <= 3'd5 && res.minutes_ones <= 4'd9 &&
        res.seconds_tens <= 3'd5 && res.seconds_ones <= 4'd9)
    `ASSERT_IMPL(a_expired_zero, i_clk, i_rst_n, r_vo && res.expired,
        res.remaining == 16'd0 && !res.running && !res.by_win)
    `ASSERT_IMPL(a_win_zero, i_clk, i_rst_n, r_vo && res.by_win,
        res.remaining == 16'd0 && !res.running)
    `ASSERT_IMPL(a_running_nonzero, i_clk, i_rst_n, r_vo && res.running,
        res.remaining != 16'd0)
    `ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_v1 && !load2, r_v1)

endmodule

[dv/stc_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stc_checker
// Watches the configuration, command and readout channels of the countdown
// timer, tracks the countdown state on its own and compares every readout
// field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module stc_checker #(
    parameter int FRAMES_PER_SECOND = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [15:0]       i_cfg_seconds,
    // command channel
    input  logic              i_cmd_valid,
    input  logic              i_cmd_ready,
    input  logic [1:0]        i_command,
    input  logic              i_freeze,
    input  logic              i_win,
    // readout channel
    input  logic              i_rd_valid,
    input  logic              i_rd_ready,
    input  stc_pkg::t_result  i_readout,
    // status toward the testbench top
    output int                o_fail_count,
    output int                o_awaiting,
    output int                o_readout_count,
    output int                o_expiry_count,
    output int                o_win_count
);
    import stc_pkg::*;

    logic [15:0] length_cfg;
    logic [15:0] seconds_left;
    logic [5:0]  frame_phase;
    logic        counting;
    t_result     readouts_due[$];

    initial begin
        o_fail_count    = 0;
        o_awaiting      = 0;
        o_readout_count = 0;
        o_expiry_count  = 0;
        o_win_count     = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("readout %0d field %s: got %0d, expected %0d",
                             o_readout_count, name, got, want));
    endtask

    // Advance the countdown by one command transaction and queue its readout.
    task automatic step_countdown(input logic [1:0] cmd, input logic frz, input logic wn);
        t_result r;
        int      hrs;
        int      mins;
        int      secs;
        r = '0;
        case (cmd)
            CMD_RESET: begin
                seconds_left = length_cfg;
                counting     = 1'b0;
                frame_phase  = '0;
            end
            CMD_START: begin
                if (!counting) begin
                    if (length_cfg == 16'd0) begin
                        seconds_left = '0;
                    end else begin
                        if (seconds_left == 16'd0 || seconds_left > length_cfg)
                            seconds_left = length_cfg;
                        counting    = 1'b1;
                        frame_phase = '0;
                    end
                end
            end
            CMD_TICK: begin
                if (counting && seconds_left != 16'd0 && !frz) begin
                    frame_phase = frame_phase + 6'd1;
                    if (frame_phase >= FRAMES_PER_SECOND) begin
                        frame_phase  = '0;
                        seconds_left = seconds_left - 16'd1;
                        // win beats expiry when both land on the same boundary
                        if (wn) begin
                            counting     = 1'b0;
                            seconds_left = '0;
                            r.by_win     = 1'b1;
                        end else if (seconds_left == 16'd0) begin
                            counting  = 1'b0;
                            r.expired = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        hrs  = int'(seconds_left) / 3600;
        mins = (int'(seconds_left) / 60) % 60;
        secs = int'(seconds_left) % 60;

        r.remaining    = seconds_left;
        r.urgent       = (length_cfg != 16'd0) && (seconds_left <= (length_cfg >> 1));
        r.running      = counting;
        r.hours_tens   = 1'(hrs / 10);
        r.hours_ones   = 4'(hrs % 10);
        r.minutes_tens = 3'(mins / 10);
        r.minutes_ones = 4'(mins % 10);
        r.seconds_tens = 3'(secs / 10);
        r.seconds_ones = 4'(secs % 10);

        if (r.expired) o_expiry_count++;
        if (r.by_win)  o_win_count++;
        readouts_due.push_back(r);
    endtask

    task automatic check_readout(input t_result got);
        t_result want;
        if (readouts_due.size() == 0) begin
            report("readout transaction with no prediction outstanding");
        end else begin
            want = readouts_due.pop_front();
            check_field("remaining_seconds", int'(got.remaining),    int'(want.remaining));
            check_field("urgent",            int'(got.urgent),       int'(want.urgent));
            check_field("expired",           int'(got.expired),      int'(want.expired));
            check_field("stopped_by_win",    int'(got.by_win),       int'(want.by_win));
            check_field("running",           int'(got.running),      int'(want.running));
            check_field("hours_tens",        int'(got.hours_tens),   int'(want.hours_tens));
            check_field("hours_ones",        int'(got.hours_ones),   int'(want.hours_ones));
            check_field("minutes_tens",      int'(got.minutes_tens), int'(want.minutes_tens));
            check_field("minutes_ones",      int'(got.minutes_ones), int'(want.minutes_ones));
            check_field("seconds_tens",      int'(got.seconds_tens), int'(want.seconds_tens));
            check_field("seconds_ones",      int'(got.seconds_ones), int'(want.seconds_ones));
        end
        o_readout_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            length_cfg   = '0;
            seconds_left = '0;
            frame_phase  = '0;
            counting     = 1'b0;
            readouts_due.delete();
        end else begin
            if (i_rd_valid && i_rd_ready)
                check_readout(i_readout);
            if (i_cfg_valid && i_cfg_ready)
                length_cfg = i_cfg_seconds;
            if (i_cmd_valid && i_cmd_ready)
                step_countdown(i_command, i_freeze, i_win);
        end
        o_awaiting = readouts_due.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the seconds countdown timer: directed corner
// commands, then randomized countdown sessions under several lengths, with
// random gaps on the command side and random stalls on the readout side.
// ---------------------------------------------------------------------------
module testbench;
    import stc_pkg::*;

    localparam int         FPS          = 60;
    localparam int         PIPE_LATENCY = 3;
    localparam int         ITEM_TARGET  = 1850;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam logic [1:0] CMD_SPARE    = 2'd3;   // unused code, must be ignored

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_configured_seconds;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic        i_freeze;
    logic        i_win;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic [15:0] o_remaining_seconds;
    logic        o_urgent;
    logic        o_expired;
    logic        o_stopped_by_win;
    logic        o_running;
    logic        o_hours_tens;
    logic [3:0]  o_hours_ones;
    logic [2:0]  o_minutes_tens;
    logic [3:0]  o_minutes_ones;
    logic [2:0]  o_seconds_tens;
    logic [3:0]  o_seconds_ones;

    t_result     seen_readout;
    int          fail_count;
    int          awaiting;
    int          readout_count;
    int          expiry_count;
    int          win_count;
    int          items_sent = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;
    bit          sender_calm = 1'b0;
    bit          reader_calm = 1'b0;
    int          stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    seconds_countdown_timer #(
        .FRAMES_PER_SECOND(FPS)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_configured_seconds(i_configured_seconds),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_command           (i_command),
        .i_freeze            (i_freeze),
        .i_win               (i_win),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_remaining_seconds (o_remaining_seconds),
        .o_urgent            (o_urgent),
        .o_expired           (o_expired),
        .o_stopped_by_win    (o_stopped_by_win),
        .o_running           (o_running),
        .o_hours_tens        (o_hours_tens),
        .o_hours_ones        (o_hours_ones),
        .o_minutes_tens      (o_minutes_tens),
        .o_minutes_ones      (o_minutes_ones),
        .o_seconds_tens      (o_seconds_tens),
        .o_seconds_ones      (o_seconds_ones)
    );

    assign seen_readout = {o_remaining_seconds, o_urgent, o_expired, o_stopped_by_win,
                           o_running, o_hours_tens, o_hours_ones, o_minutes_tens,
                           o_minutes_ones, o_seconds_tens, o_seconds_ones};

    stc_checker #(
        .FRAMES_PER_SECOND(FPS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_seconds  (i_configured_seconds),
        .i_cmd_valid    (i_valid),
        .i_cmd_ready    (o_ready),
        .i_command      (i_command),
        .i_freeze       (i_freeze),
        .i_win          (i_win),
        .i_rd_valid     (o_valid),
        .i_rd_ready     (i_ready),
        .i_readout      (seen_readout),
        .o_fail_count   (fail_count),
        .o_awaiting     (awaiting),
        .o_readout_count(readout_count),
        .o_expiry_count (expiry_count),
        .o_win_count    (win_count)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            pick_idle = $urandom_range(3, 1);
        else if (roll < 97)
            pick_idle = $urandom_range(12, 4);
        else
            pick_idle = $urandom_range(60, 20);
    endfunction

    // Readout side backpressure, with calm stretches of no stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(399) == 0)
            reader_calm = !reader_calm;
        if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else begin
            i_ready = 1'b1;
            if (!reader_calm && $urandom_range(99) < 25)
                stall_left = pick_idle();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic drive_item(input logic [1:0] cmd, input logic frz, input logic wn);
        int gap;
        i_valid   = 1'b1;
        i_command = cmd;
        i_freeze  = frz;
        i_win     = wn;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        gap = (sender_calm || $urandom_range(99) >= 35) ? 0 : pick_idle();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [15:0] len);
        wait_idle();
        i_cfg_valid          = 1'b1;
        i_configured_seconds = len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // Short lengths make expiry reachable; the rest exercise the digit split.
    function automatic logic [15:0] pick_length();
        case ($urandom_range(9))
            0:       pick_length = 16'd0;
            1:       pick_length = 16'd1;
            2:       pick_length = 16'($urandom_range(3, 2));
            3:       pick_length = 16'hFFFF;
            4:       pick_length = 16'($urandom_range(65535));
            5:       pick_length = 16'($urandom_range(61, 59));
            6:       pick_length = 16'($urandom_range(3601, 3599));
            7:       pick_length = 16'($urandom_range(20, 4));
            8:       pick_length = 16'($urandom_range(200, 1));
            default: pick_length = 16'($urandom_range(40000, 35990));
        endcase
    endfunction

    task automatic run_session(input int n_items, input bit noisy, input int win_pct);
        int         k;
        int         roll;
        logic [1:0] cmd;
        for (k = 0; k < n_items; k++) begin
            roll = $urandom_range(999);
            if (noisy)
                cmd = 2'($urandom_range(3));
            else if (roll < 5)
                cmd = CMD_RESET;
            else if (roll < 25)
                cmd = CMD_START;
            else if (roll < 35)
                cmd = CMD_SPARE;
            else
                cmd = CMD_TICK;
            drive_item(cmd, $urandom_range(99) < 8, $urandom_range(99) < win_pct);
        end
    endtask

    initial begin
        int opener;
        int roll;
        int win_pct;
        int n_run;

        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_configured_seconds = '0;
        i_valid              = 1'b0;
        i_command            = CMD_RESET;
        i_freeze             = 1'b0;
        i_win                = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // nothing configured: ticks idle, start forces zero and stays stopped
        drive_item(CMD_TICK, 1'b0, 1'b0);
        drive_item(CMD_START, 1'b0, 1'b0);
        drive_item(CMD_SPARE, 1'b1, 1'b1);
        drive_item(CMD_RESET, 1'b0, 1'b0);

        // longest length: 18:12:15, start twice, frozen and plain ticks
        write_length(16'hFFFF);
        drive_item(CMD_RESET, 1'b1, 1'b1);
        drive_item(CMD_START, 1'b0, 1'b0);
        drive_item(CMD_START, 1'b1, 1'b0);
        drive_item(CMD_TICK, 1'b1, 1'b0);
        drive_item(CMD_TICK, 1'b0, 1'b0);
        drive_item(CMD_TICK, 1'b0, 1'b1);
        drive_item(CMD_SPARE, 1'b1, 1'b1);

        // stored remainder above the new length gets clamped on start
        write_length(16'd100);
        drive_item(CMD_RESET, 1'b0, 1'b0);
        write_length(16'd5);
        drive_item(CMD_START, 1'b0, 1'b0);
        // length raised while running: count untouched, urgency follows
        write_length(16'd100);
        drive_item(CMD_TICK, 1'b0, 1'b0);
        drive_item(CMD_SPARE, 1'b0, 1'b0);

        // stored remainder below the new length is kept on start
        drive_item(CMD_RESET, 1'b0, 1'b0);
        write_length(16'd7);
        drive_item(CMD_RESET, 1'b0, 1'b0);
        write_length(16'd3600);
        drive_item(CMD_START, 1'b0, 1'b0);
        drive_item(CMD_TICK, 1'b0, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 70)
                write_length(pick_length());
            else
                wait_idle();
            sender_calm = ($urandom_range(99) < 20);
            roll = $urandom_range(99);
            win_pct = (roll < 50) ? 0 : (roll < 80) ? 2 : 40;
            opener = $urandom_range(99);
            if (opener < 60) begin
                drive_item(CMD_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)));
                drive_item(CMD_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (opener < 85) begin
                drive_item(CMD_START, 1'b0, 1'b0);
            end
            // keep the total close to the target
            n_run = $urandom_range(220, 80);
            if (n_run > ITEM_TARGET - items_sent)
                n_run = ITEM_TARGET - items_sent;
            run_session(n_run, $urandom_range(99) < 15, win_pct);
        end

        i_valid = 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 5) @(negedge i_clk);

        $display("Ran %0d commands over %0d length settings; %0d readouts checked.",
                 items_sent, cfg_writes, readout_count);
        $display("Countdowns ended by expiry: %0d, stopped by win: %0d.",
                 expiry_count, win_count);
        if (fail_count == 0 && awaiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
